FILE: rtl/core/char_lcd_nibble_writer_core_assert.svh
// Assertion macros for the character LCD nibble writer core
`ifndef CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_WRITER_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CLNW_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("char_lcd_nibble_writer_core: assertion failed");

// next-cycle implication, disabled during reset
`define CLNW_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("char_lcd_nibble_writer_core: assertion failed");

`endif

FILE: rtl/core/clnw_pkg.sv
// Package with shared types, codes and the nibble sequence table of the LCD writer
`default_nettype none
package clnw_pkg;

   localparam int ACTION_W = 3;
   localparam int CHAR_W = 8;
   localparam int LINE_W = 8;
   localparam int ADDR_W = 7;
   localparam int PORT_W = 8;
   localparam int ROWS = 4;
   localparam int ROW_IDX_W = 2;
   localparam int NIB_PTR_W = 4;

   localparam logic [ACTION_W-1:0] ACT_INIT      = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_NEXT_LINE = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_MOVE_LINE = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SET_ADDR  = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_WRITE_CHR = 3'd5;

   localparam logic [ROW_IDX_W-1:0] CSR_ROW0 = 2'd0;
   localparam logic [ROW_IDX_W-1:0] CSR_ROW1 = 2'd1;
   localparam logic [ROW_IDX_W-1:0] CSR_ROW2 = 2'd2;
   localparam logic [ROW_IDX_W-1:0] CSR_ROW3 = 2'd3;

   localparam logic [ADDR_W-1:0] ROW0_RESET = 7'd0;
   localparam logic [ADDR_W-1:0] ROW1_RESET = 7'd64;
   localparam logic [ADDR_W-1:0] ROW2_RESET = 7'd20;
   localparam logic [ADDR_W-1:0] ROW3_RESET = 7'd84;

   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_ADDR  = 2'd2;
   localparam logic [1:0] MODE_CHAR  = 2'd3;

   localparam logic [NIB_PTR_W-1:0] SEQ_INIT_START  = 4'd0;
   localparam logic [NIB_PTR_W-1:0] SEQ_CLEAR_START = 4'd10;
   localparam logic [NIB_PTR_W-1:0] SEQ_LAST        = 4'd13;
   localparam logic [NIB_PTR_W-1:0] PAIR_START      = 4'd0;

   typedef struct packed {
      logic [1:0]        mode;
      logic [CHAR_W-1:0] cmd_byte;
   } cmd_type;

   typedef struct packed {
      logic not_empty;
      logic pop;
   } fifo_ctl_type;

   function automatic logic [3:0] seq_nibble(input logic [NIB_PTR_W-1:0] idx);
      logic [3:0] nib;
      unique case (idx)
         4'd0:    nib = 4'h3;
         4'd1:    nib = 4'h3;
         4'd2:    nib = 4'h3;
         4'd3:    nib = 4'h2;
         4'd4:    nib = 4'h2;
         4'd5:    nib = 4'h8;
         4'd6:    nib = 4'h0;
         4'd7:    nib = 4'hC;
         4'd8:    nib = 4'h0;
         4'd9:    nib = 4'h6;
         4'd10:   nib = 4'h0;
         4'd11:   nib = 4'h1;
         4'd12:   nib = 4'h0;
         4'd13:   nib = 4'h2;
         default: nib = 4'h0;
      endcase
      return nib;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/clnw_cmd_fifo.sv
// Two-entry command queue between the front and back parts
`default_nettype none
module clnw_cmd_fifo
   import clnw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  cmd_type      push_cmd,
   output logic         fifo_full,
   input  logic         fifo_pop,
   output logic         fifo_not_empty,
   output cmd_type      head_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign fifo_full      = (count_ff == 2'd2);
   assign fifo_not_empty = (count_ff != 2'd0);
   assign head_cmd       = entry_ff[rd_ptr_ff];
   assign do_push        = push && !fifo_full;
   assign do_pop         = fifo_pop && fifo_not_empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/clnw_front.sv
// Front part: accepts actions, holds row registers and line counter, builds commands
`default_nettype none
module clnw_front
   import clnw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [ROW_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   input  logic                 accept,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [CHAR_W-1:0]    req_char_byte,
   input  logic [LINE_W-1:0]    req_line_number,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 cmd_push,
   output cmd_type              cmd
);

   logic [ADDR_W-1:0]    row_ff [ROWS];
   logic [ROW_IDX_W-1:0] line_ff, line_in;
   logic [ROW_IDX_W-1:0] row_sel;
   logic [ADDR_W-1:0]    row_addr;

   assign row_sel  = (req_action == ACT_MOVE_LINE) ? req_line_number[ROW_IDX_W-1:0] : line_ff;
   assign row_addr = row_ff[row_sel];

   always_comb begin
      cmd_push = accept;
      cmd      = '{mode: MODE_CHAR, cmd_byte: req_char_byte};
      line_in  = line_ff;
      unique case (req_action)
         ACT_INIT: begin
            cmd.mode = MODE_INIT;
            line_in  = '0;
         end
         ACT_CLEAR: begin
            cmd.mode = MODE_CLEAR;
            line_in  = '0;
         end
         ACT_NEXT_LINE: begin
            cmd = '{mode: MODE_ADDR, cmd_byte: {1'b1, row_addr}};
            line_in = line_ff + 2'd1;
         end
         ACT_MOVE_LINE: begin
            cmd = '{mode: MODE_ADDR, cmd_byte: {1'b1, row_addr}};
            line_in = req_line_number[ROW_IDX_W-1:0];
         end
         ACT_SET_ADDR: begin
            cmd = '{mode: MODE_ADDR, cmd_byte: {1'b1, req_address}};
         end
         ACT_WRITE_CHR: begin
            cmd.mode = MODE_CHAR;
         end
         default: begin
            // drop unused action codes
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0;
      end else if (accept) begin
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[CSR_ROW0] <= ROW0_RESET;
         row_ff[CSR_ROW1] <= ROW1_RESET;
         row_ff[CSR_ROW2] <= ROW2_RESET;
         row_ff[CSR_ROW3] <= ROW3_RESET;
      end else if (csr_valid) begin
         row_ff[csr_index] <= csr_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/clnw_back.sv
// Back part: walks the nibble sequence of each command and emits port writes
`default_nettype none
module clnw_back
   import clnw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  cmd_type           head_cmd,
   output fifo_ctl_type      fifo_ctl,
   output logic              empty,
   input  logic              pop,
   output logic [PORT_W-1:0] rsp_port_value,
   output logic              rsp_wait_long,
   output logic              rsp_last
);

   logic                 busy_ff, busy_in;
   logic [1:0]           mode_ff;
   logic [CHAR_W-1:0]    byte_ff;
   logic [NIB_PTR_W-1:0] ptr_ff, ptr_in;
   logic                 phase_ff, phase_in;
   logic                 out_valid_ff, out_valid_in;
   logic [PORT_W-1:0]    out_value_ff;
   logic                 out_wait_ff;
   logic                 out_last_ff;

   logic                 is_seq;
   logic [3:0]           nib;
   logic [PORT_W-1:0]    value;
   logic                 step_last;
   logic                 wait_flag;
   logic                 emit;
   logic                 load;

   always_comb begin
      is_seq    = (mode_ff == MODE_INIT) || (mode_ff == MODE_CLEAR);
      nib       = is_seq ? seq_nibble(ptr_ff) : (ptr_ff[0] ? byte_ff[3:0] : byte_ff[7:4]);
      value     = {(mode_ff == MODE_CHAR), 1'b0, ~phase_ff,
                   nib[0], nib[1], nib[2], nib[3], 1'b0};
      step_last = phase_ff && (is_seq ? (ptr_ff == SEQ_LAST) : ptr_ff[0]);
      wait_flag = (mode_ff == MODE_INIT) && (ptr_ff == SEQ_INIT_START) && phase_ff;
      emit      = busy_ff && (!out_valid_ff || pop);
      load      = head_valid && (!busy_ff || (emit && step_last));
   end

   assign fifo_ctl = '{not_empty: head_valid, pop: load};

   always_comb begin
      busy_in  = busy_ff;
      ptr_in   = ptr_ff;
      phase_in = phase_ff;
      priority if (load) begin
         busy_in  = 1'b1;
         ptr_in   = (head_cmd.mode == MODE_CLEAR) ? SEQ_CLEAR_START :
                    ((head_cmd.mode == MODE_INIT) ? SEQ_INIT_START : PAIR_START);
         phase_in = 1'b0;
      end else if (emit) begin
         if (step_last) begin
            busy_in = 1'b0;
         end else begin
            phase_in = ~phase_ff;
            ptr_in   = ptr_ff + {{(NIB_PTR_W-1){1'b0}}, phase_ff};
         end
      end else begin
         // hold
      end
      out_valid_in = emit ? 1'b1 : (pop ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff   <= ptr_in;
      phase_ff <= phase_in;
      if (load) begin
         mode_ff <= head_cmd.mode;
         byte_ff <= head_cmd.cmd_byte;
      end
      if (emit) begin
         out_value_ff <= value;
         out_wait_ff  <= wait_flag;
         out_last_ff  <= step_last;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_port_value = out_value_ff;
   assign rsp_wait_long  = out_wait_ff;
   assign rsp_last       = out_last_ff;

endmodule
`default_nettype wire

FILE: rtl/core/char_lcd_nibble_writer_core.sv
// Top level of the character LCD nibble writer: front, command queue, back
//
//   channel  handshake           payload
//   req      push / full         action, char_byte, line_number, address
//   rsp      empty / pop         port_value, wait_long, last
//   csr      valid / ready       index (row register), data
//
// One port write per cycle leaves the back part unless rsp stalls; the nibble
// walker sends 2 nibbles (address, character), 4 (clear) or 14 (init).
// The two-entry queue takes new actions while a command is being written.
// Reset is synchronous: row registers return to 0/64/20/84, line counter to 0.
// A stalled rsp side holds the output register and backs up into req full.
`default_nettype none
`include "char_lcd_nibble_writer_core_assert.svh"
module char_lcd_nibble_writer_core
   import clnw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [CHAR_W-1:0]    req_char_byte,
   input  logic [LINE_W-1:0]    req_line_number,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 empty,
   input  logic                 pop,
   output logic [PORT_W-1:0]    rsp_port_value,
   output logic                 rsp_wait_long,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [ROW_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data
);

   logic         accept;
   logic         cmd_push;
   cmd_type      cmd;
   cmd_type      head_cmd;
   logic         head_valid;
   fifo_ctl_type fifo_ctl;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;

   clnw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .accept          (accept),
      .req_action      (req_action),
      .req_char_byte   (req_char_byte),
      .req_line_number (req_line_number),
      .req_address     (req_address),
      .cmd_push        (cmd_push),
      .cmd             (cmd)
   );

   clnw_cmd_fifo u_fifo (
      .clock          (clock),
      .reset          (reset),
      .push           (cmd_push),
      .push_cmd       (cmd),
      .fifo_full      (full),
      .fifo_pop       (fifo_ctl.pop),
      .fifo_not_empty (head_valid),
      .head_cmd       (head_cmd)
   );

   clnw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .fifo_ctl       (fifo_ctl),
      .empty          (empty),
      .pop            (pop),
      .rsp_port_value (rsp_port_value),
      .rsp_wait_long  (rsp_wait_long),
      .rsp_last       (rsp_last)
   );

   `CLNW_ASSERT_IMP(a_wait_on_low_enable, clock, reset, !empty && rsp_wait_long, !rsp_port_value[5] && !rsp_port_value[7])
   `CLNW_ASSERT_IMP(a_last_on_low_enable, clock, reset, !empty && rsp_last, !rsp_port_value[5])
   `CLNW_ASSERT_IMP(a_pop_needs_entry, clock, reset, fifo_ctl.pop, fifo_ctl.not_empty)
   `CLNW_ASSERT_NXT(a_enable_pairs, clock, reset, !empty && pop && rsp_port_value[5], !empty || $past(full))

endmodule
`default_nettype wire

FILE: bench/clnw_port_write_checker.sv
// Checker for the LCD nibble writer: predicts port writes per action and compares transfers
`default_nettype none
module clnw_port_write_checker
   import clnw_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic                 full,
   input  logic [ACTION_W-1:0]  req_action,
   input  logic [CHAR_W-1:0]    req_char_byte,
   input  logic [LINE_W-1:0]    req_line_number,
   input  logic [ADDR_W-1:0]    req_address,
   input  logic                 empty,
   input  logic                 pop,
   input  logic [PORT_W-1:0]    rsp_port_value,
   input  logic                 rsp_wait_long,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [ROW_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output int                   failures,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENABLE_POS = 5;
   localparam logic [39:0] INIT_NIBBLES = 40'h3332_280C_06;
   localparam logic [15:0] CLEAR_NIBBLES = 16'h0102;

   typedef struct packed {
      logic [PORT_W-1:0] port_value;
      logic              wait_long;
      logic              last;
   } port_write_type;

   logic [ADDR_W-1:0]    row_addr [ROWS];
   logic [ROW_IDX_W-1:0] line_count;
   port_write_type       pending_writes [$];
   port_write_type       action_writes [$];
   int                   write_count;

   initial begin
      failures = 0;
      pending = 0;
      write_count = 0;
   end

   function automatic void add_nibble(input logic data_sel, input logic [3:0] nib);
      port_write_type w;
      w.port_value = {data_sel, 1'b0, 1'b1, nib[0], nib[1], nib[2], nib[3], 1'b0};
      w.wait_long = 1'b0;
      w.last = 1'b0;
      action_writes.push_back(w);
      w.port_value[ENABLE_POS] = 1'b0;
      action_writes.push_back(w);
   endfunction

   function automatic void add_set_address(input logic [ADDR_W-1:0] addr);
      add_nibble(1'b0, {1'b1, addr[6:4]});
      add_nibble(1'b0, addr[3:0]);
   endfunction

   function automatic void add_clear();
      for (int i = 0; i < 4; i++) begin
         add_nibble(1'b0, CLEAR_NIBBLES[15-4*i -: 4]);
      end
      line_count = '0;
   endfunction

   function automatic void predict_port_writes(input logic [ACTION_W-1:0] act,
                                               input logic [CHAR_W-1:0]   ch,
                                               input logic [LINE_W-1:0]   ln,
                                               input logic [ADDR_W-1:0]   addr);
      port_write_type w;
      int n;
      action_writes.delete();
      case (act)
         ACT_INIT: begin
            for (int i = 0; i < 10; i++) begin
               add_nibble(1'b0, INIT_NIBBLES[39-4*i -: 4]);
            end
            add_clear();
         end
         ACT_CLEAR: begin
            add_clear();
         end
         ACT_NEXT_LINE: begin
            add_set_address(row_addr[line_count]);
            line_count = line_count + 1'b1;
         end
         ACT_MOVE_LINE: begin
            line_count = ln[ROW_IDX_W-1:0];
            add_set_address(row_addr[line_count]);
         end
         ACT_SET_ADDR: begin
            add_set_address(addr);
         end
         ACT_WRITE_CHR: begin
            add_nibble(1'b1, ch[7:4]);
            add_nibble(1'b1, ch[3:0]);
         end
         default: begin
         end
      endcase
      n = action_writes.size();
      for (int k = 0; k < n; k++) begin
         w = action_writes[k];
         w.wait_long = (act == ACT_INIT) && (k == 1);
         w.last = (k == n - 1);
         pending_writes.push_back(w);
      end
   endfunction

   task automatic report(input string msg);
      $display("%0t ns: port write %0d: %s", $time, write_count, msg);
      failures++;
   endtask

   always @(posedge clock) begin
      port_write_type want;
      if (reset) begin
         row_addr[CSR_ROW0] = ROW0_RESET;
         row_addr[CSR_ROW1] = ROW1_RESET;
         row_addr[CSR_ROW2] = ROW2_RESET;
         row_addr[CSR_ROW3] = ROW3_RESET;
         line_count = '0;
         pending_writes.delete();
         write_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            row_addr[csr_index] = csr_data;
         end
         if (push && !full) begin
            predict_port_writes(req_action, req_char_byte, req_line_number, req_address);
         end
         if (pop && !empty) begin
            if (pending_writes.size() == 0) begin
               report($sformatf("unexpected transfer, port_value 0x%02h", rsp_port_value));
            end else begin
               want = pending_writes.pop_front();
               if (rsp_port_value !== want.port_value) begin
                  report($sformatf("port_value expected 0x%02h, got 0x%02h",
                                   want.port_value, rsp_port_value));
               end
               if (rsp_wait_long !== want.wait_long) begin
                  report($sformatf("wait_long expected %0b, got %0b",
                                   want.wait_long, rsp_wait_long));
               end
               if (rsp_last !== want.last) begin
                  report($sformatf("last expected %0b, got %0b", want.last, rsp_last));
               end
            end
            write_count++;
         end
      end
      pending = pending_writes.size();
   end

endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Top of the LCD nibble writer bench: clock, reset, stimulus, watchdog and verdict
`default_nettype none
module testbench;
   import clnw_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT = 4000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 push = 1'b0;
   logic                 full;
   logic [ACTION_W-1:0]  req_action = '0;
   logic [CHAR_W-1:0]    req_char_byte = '0;
   logic [LINE_W-1:0]    req_line_number = '0;
   logic [ADDR_W-1:0]    req_address = '0;
   logic                 empty;
   logic                 pop = 1'b0;
   logic [PORT_W-1:0]    rsp_port_value;
   logic                 rsp_wait_long;
   logic                 rsp_last;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [ROW_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_data = '0;
   int                   failures;
   int                   pending;
   bit                   calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   char_lcd_nibble_writer_core dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_action(req_action), .req_char_byte(req_char_byte),
      .req_line_number(req_line_number), .req_address(req_address),
      .empty(empty), .pop(pop),
      .rsp_port_value(rsp_port_value), .rsp_wait_long(rsp_wait_long), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   clnw_port_write_checker u_checker (
      .clock(clock), .reset(reset),
      .push(push), .full(full),
      .req_action(req_action), .req_char_byte(req_char_byte),
      .req_line_number(req_line_number), .req_address(req_address),
      .empty(empty), .pop(pop),
      .rsp_port_value(rsp_port_value), .rsp_wait_long(rsp_wait_long), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .failures(failures), .pending(pending)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   // sink: stall at random, hold pop steady through calm phases
   initial begin
      int hold;
      hold = 0;
      @(negedge clock);
      forever begin
         if (hold > 0) begin
            pop <= 1'b0;
            hold--;
         end else begin
            pop <= 1'b1;
            hold = pick_gap();
         end
         @(negedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      while (idle < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
            idle = 0;
         end else begin
            idle++;
         end
      end
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_action(input logic [ACTION_W-1:0] act,
                              input logic [CHAR_W-1:0]   ch,
                              input logic [LINE_W-1:0]   ln,
                              input logic [ADDR_W-1:0]   addr);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_action <= act;
      req_char_byte <= ch;
      req_line_number <= ln;
      req_address <= addr;
      @(posedge clock);
      while (full) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      push <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_row(input logic [ROW_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_rows(input logic [ADDR_W-1:0] r0, input logic [ADDR_W-1:0] r1,
                             input logic [ADDR_W-1:0] r2, input logic [ADDR_W-1:0] r3);
      write_row(CSR_ROW0, r0);
      write_row(CSR_ROW1, r1);
      write_row(CSR_ROW2, r2);
      write_row(CSR_ROW3, r3);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      int r;
      logic [ACTION_W-1:0] act;
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 40)      act = ACT_WRITE_CHR;
         else if (r < 55) act = ACT_NEXT_LINE;
         else if (r < 68) act = ACT_MOVE_LINE;
         else if (r < 82) act = ACT_SET_ADDR;
         else if (r < 89) act = ACT_CLEAR;
         else if (r < 94) act = ACT_INIT;
         else if (r < 97) act = ACT_SPARE_LO;
         else             act = ACT_SPARE_HI;
         send_action(act, CHAR_W'($urandom), LINE_W'($urandom), ADDR_W'($urandom));
      end
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_action(ACT_INIT, 8'h00, 8'h00, 7'h00);
      send_action(ACT_CLEAR, 8'hFF, 8'hFF, 7'h7F);
      send_action(ACT_WRITE_CHR, 8'h00, 8'h00, 7'h00);
      send_action(ACT_WRITE_CHR, 8'hFF, 8'h00, 7'h00);
      send_action(ACT_WRITE_CHR, 8'hA5, 8'h00, 7'h00);
      send_action(ACT_WRITE_CHR, 8'h5A, 8'h00, 7'h00);
      send_action(ACT_SET_ADDR, 8'h00, 8'h00, 7'h00);
      send_action(ACT_SET_ADDR, 8'h00, 8'h00, 7'h7F);
      send_action(ACT_SET_ADDR, 8'h00, 8'h00, 7'h55);
      send_action(ACT_MOVE_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_MOVE_LINE, 8'h00, 8'h01, 7'h00);
      send_action(ACT_MOVE_LINE, 8'h00, 8'h02, 7'h00);
      send_action(ACT_MOVE_LINE, 8'h00, 8'h03, 7'h00);
      send_action(ACT_MOVE_LINE, 8'h00, 8'hFF, 7'h00);
      send_action(ACT_MOVE_LINE, 8'h00, 8'hFC, 7'h00);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);
      send_action(ACT_SPARE_LO, 8'hFF, 8'hFF, 7'h7F);
      send_action(ACT_SPARE_HI, 8'h3C, 8'h01, 7'h2A);
      send_action(ACT_NEXT_LINE, 8'h00, 8'h00, 7'h00);

      drain();
      write_rows(7'h7F, 7'h7F, 7'h7F, 7'h7F);
      send_random(45);

      drain();
      write_rows(7'h00, 7'h00, 7'h00, 7'h00);
      calm = 1'b1;
      send_random(35);
      calm = 1'b0;

      drain();
      send_random(30);

      drain();
      write_rows(ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom), ADDR_W'($urandom));
      send_random(45);

      drain();
      if (pending != 0) begin
         $display("%0d expected port writes never arrived", pending);
      end
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+rtl/core
rtl/core/clnw_pkg.sv
rtl/core/clnw_cmd_fifo.sv
rtl/core/clnw_front.sv
rtl/core/clnw_back.sv
rtl/core/char_lcd_nibble_writer_core.sv
bench/clnw_port_write_checker.sv
bench/testbench.sv
